@@ rtl/gcsm_pkg.sv @@
// Package for the ghost cell source mapper: wall kind codes, register
// indexes, grid limits, field widths and the shared structs.
// No dependencies.
`default_nettype none

package gcsm_pkg;

    localparam int unsigned PADDED_MAX   = 1024;
    localparam int unsigned GHOST_LAYERS = 2;
    localparam int unsigned COORD_W      = 10;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned IN_DATA_W    = 24;
    localparam int unsigned OUT_DATA_W   = 32;

    // Extent limits for the interior count on one axis
    localparam logic [COORD_W-1:0] EXTENT_MIN = COORD_W'(2);
    localparam logic [COORD_W-1:0] EXTENT_MAX = COORD_W'(PADDED_MAX - 2 * GHOST_LAYERS);
    localparam logic [COORD_W-1:0] EXTENT_RST = COORD_W'(64);

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        KIND_OPEN     = 2'd0,
        KIND_CLOSED   = 2'd1,
        KIND_PERIODIC = 2'd2,
        KIND_FIXED    = 2'd3
    } wall_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_LEFT   = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_BOTTOM = 3'd4,
        REG_TOP    = 3'd5
    } cfg_reg_t;

    // Fixed wall codes on the output
    localparam logic [1:0] WALL_LEFT   = 2'd0;
    localparam logic [1:0] WALL_RIGHT  = 2'd1;
    localparam logic [1:0] WALL_BOTTOM = 2'd2;
    localparam logic [1:0] WALL_TOP    = 2'd3;

    // Live configuration, extents already clamped
    typedef struct packed {
        coord_t     width;
        coord_t     height;
        wall_kind_t left_kind;
        wall_kind_t right_kind;
        wall_kind_t bottom_kind;
        wall_kind_t top_kind;
        logic       config_error;
    } cfg_t;

    // Mapping of one coordinate on one axis
    typedef struct packed {
        coord_t src;
        logic   neg;
        logic   fixed;
        logic   high_wall;
        logic   ghost;
        logic   outside;
    } axis_map_t;

    function automatic coord_t clamp_extent(input coord_t n);
        coord_t r;
        if (n < EXTENT_MIN)
            r = EXTENT_MIN;
        else if (n > EXTENT_MAX)
            r = EXTENT_MAX;
        else
            r = n;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ghost_cell_source_mapper_core.sv @@
// Top level of the ghost cell source mapper: config registers, input beat
// register, per-axis mapping, corner composition and output register.
// Depends on gcsm_pkg, gcsm_cfg and gcsm_axis.
//
// Usage:
//   s_* channel: one beat per padded-grid cell coordinate.
//   m_* channel: one beat per input beat, in order, giving the source cell,
//     momentum negation flags, fixed-vector selection, ghost and config flags.
//   cfg_*: plain write port, one register per clock when cfg_we is high.
//     Write only while no beat is in flight.
// Path: an accepted beat goes into the input register, then through the
//   mapping logic into the output register, which drives m_tvalid and
//   m_tdata.
// Throughput: one beat per clock; both stages advance together whenever the
//   output register is empty or being drained.
// Stall: when m_tready is low the output beat holds; one more beat may sit
//   in the input register, after which s_tready drops.
// Reset: rst_n is asynchronous, active low. Both stages empty, extents 64,
//   all walls open.
`default_nettype none

module ghost_cell_source_mapper_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input stream
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // [9:0] cell_x, [19:10] cell_y, [23:20] zero
    input  wire logic [gcsm_pkg::IN_DATA_W-1:0]    s_tdata,
    // output stream
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [9:0] source_x, [19:10] source_y, [20] negate_x_momentum,
    // [21] negate_y_momentum, [22] take_fixed, [24:23] fixed_wall,
    // [25] is_ghost, [26] config_error, [31:27] zero
    output      logic [gcsm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [gcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gcsm_pkg::COORD_W-1:0]      cfg_data
);

    gcsm_pkg::cfg_t      cfg;
    gcsm_pkg::axis_map_t map_x;
    gcsm_pkg::axis_map_t map_y;

    // Input stage
    logic             in_valid_reg;
    gcsm_pkg::coord_t in_x_reg;
    gcsm_pkg::coord_t in_y_reg;

    // Output stage
    logic                              out_valid_reg;
    logic [gcsm_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [gcsm_pkg::OUT_DATA_W-1:0]   out_data_next;

    logic out_load;
    logic in_load;

    gcsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcsm_axis u_axis_x
    (
        .coord   (in_x_reg),
        .extent  (cfg.width),
        .lo_kind (cfg.left_kind),
        .hi_kind (cfg.right_kind),
        .map     (map_x)
    );

    gcsm_axis u_axis_y
    (
        .coord   (in_y_reg),
        .extent  (cfg.height),
        .lo_kind (cfg.bottom_kind),
        .hi_kind (cfg.top_kind),
        .map     (map_y)
    );

    // Handshake: output register frees up when empty or drained this cycle
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // Corner composition: the y-wall pass runs after the x-wall pass, so a
    // fixed y wall overrides everything; otherwise y mapping applies and the
    // x wall's result (fixed or copied) is layered underneath.
    always_comb
    begin
        gcsm_pkg::coord_t sx;
        gcsm_pkg::coord_t sy;
        logic             negx;
        logic             negy;
        logic             fix;
        logic [1:0]       wall;
        logic             ghost;

        sx    = in_x_reg;
        sy    = in_y_reg;
        negx  = 1'b0;
        negy  = 1'b0;
        fix   = 1'b0;
        wall  = gcsm_pkg::WALL_LEFT;
        ghost = 1'b0;

        // cells past the padded grid pass through untouched
        if (!map_x.outside && !map_y.outside)
        begin
            ghost = map_x.ghost || map_y.ghost;
            if (map_y.fixed)
            begin
                fix  = 1'b1;
                wall = map_y.high_wall ? gcsm_pkg::WALL_TOP : gcsm_pkg::WALL_BOTTOM;
            end
            else
            begin
                sy   = map_y.src;
                negy = map_y.neg;
                if (map_x.fixed)
                begin
                    fix  = 1'b1;
                    wall = map_x.high_wall ? gcsm_pkg::WALL_RIGHT : gcsm_pkg::WALL_LEFT;
                end
                else
                begin
                    sx   = map_x.src;
                    negx = map_x.neg;
                end
            end
            if (fix)
            begin
                sx = '0;
                sy = '0;
            end
        end

        out_data_next = {5'b0, cfg.config_error, ghost, wall, fix, negy, negx, sy, sx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_x_reg <= s_tdata[gcsm_pkg::COORD_W-1:0];
            in_y_reg <= s_tdata[2*gcsm_pkg::COORD_W-1:gcsm_pkg::COORD_W];
        end
        if (out_load)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/gcsm_cfg.sv @@
// Configuration register file for the ghost cell source mapper.
// Extents are clamped on write. Depends on gcsm_pkg.
`default_nettype none

module gcsm_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcsm_pkg::COORD_W-1:0]    cfg_data,
    output gcsm_pkg::cfg_t                       cfg
);

    gcsm_pkg::coord_t     width_reg;
    gcsm_pkg::coord_t     height_reg;
    gcsm_pkg::wall_kind_t left_reg;
    gcsm_pkg::wall_kind_t right_reg;
    gcsm_pkg::wall_kind_t bottom_reg;
    gcsm_pkg::wall_kind_t top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gcsm_pkg::EXTENT_RST;
            height_reg <= gcsm_pkg::EXTENT_RST;
            left_reg   <= gcsm_pkg::KIND_OPEN;
            right_reg  <= gcsm_pkg::KIND_OPEN;
            bottom_reg <= gcsm_pkg::KIND_OPEN;
            top_reg    <= gcsm_pkg::KIND_OPEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcsm_pkg::REG_WIDTH:  width_reg  <= gcsm_pkg::clamp_extent(cfg_data);
                gcsm_pkg::REG_HEIGHT: height_reg <= gcsm_pkg::clamp_extent(cfg_data);
                gcsm_pkg::REG_LEFT:   left_reg   <= gcsm_pkg::wall_kind_t'(cfg_data[1:0]);
                gcsm_pkg::REG_RIGHT:  right_reg  <= gcsm_pkg::wall_kind_t'(cfg_data[1:0]);
                gcsm_pkg::REG_BOTTOM: bottom_reg <= gcsm_pkg::wall_kind_t'(cfg_data[1:0]);
                gcsm_pkg::REG_TOP:    top_reg    <= gcsm_pkg::wall_kind_t'(cfg_data[1:0]);
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    always_comb
    begin
        cfg.width       = width_reg;
        cfg.height      = height_reg;
        cfg.left_kind   = left_reg;
        cfg.right_kind  = right_reg;
        cfg.bottom_kind = bottom_reg;
        cfg.top_kind    = top_reg;
        // periodic on one side of an axis only
        cfg.config_error =
            ((left_reg == gcsm_pkg::KIND_PERIODIC) != (right_reg == gcsm_pkg::KIND_PERIODIC)) ||
            ((bottom_reg == gcsm_pkg::KIND_PERIODIC) != (top_reg == gcsm_pkg::KIND_PERIODIC));
    end

endmodule

`default_nettype wire

@@ rtl/gcsm_axis.sv @@
// Single-axis ghost mapping: classifies a padded coordinate and picks its
// source per wall kind. Pure combinational. Depends on gcsm_pkg.
`default_nettype none

module gcsm_axis
(
    input  wire gcsm_pkg::coord_t      coord,
    input  wire gcsm_pkg::coord_t      extent,
    input  wire gcsm_pkg::wall_kind_t  lo_kind,
    input  wire gcsm_pkg::wall_kind_t  hi_kind,
    output gcsm_pkg::axis_map_t        map
);

    localparam int unsigned EW = gcsm_pkg::COORD_W + 1;

    logic [EW-1:0] c_ext;
    logic [EW-1:0] n_p1;
    logic [EW-1:0] n_p2;
    logic [EW-1:0] n_p3;
    logic [EW-1:0] hi_off;
    logic          layer;     // 0 = inner ghost, next to the interior
    logic          is_low;
    logic          is_high;

    assign c_ext   = {1'b0, coord};
    assign n_p1    = {1'b0, extent} + EW'(1);
    assign n_p2    = {1'b0, extent} + EW'(2);
    assign n_p3    = {1'b0, extent} + EW'(3);
    assign hi_off  = c_ext - n_p2;
    assign is_low  = (coord < gcsm_pkg::COORD_W'(2));
    assign is_high = (c_ext >= n_p2);
    assign layer   = is_low ? ~coord[0] : hi_off[0];

    always_comb
    begin
        map.src       = coord;
        map.neg       = 1'b0;
        map.fixed     = 1'b0;
        map.high_wall = 1'b0;
        map.ghost     = 1'b0;
        map.outside   = 1'b0;
        if (c_ext > n_p3)
        begin
            map.outside = 1'b1;
        end
        else if (is_low)
        begin
            map.ghost = 1'b1;
            case (lo_kind)
                gcsm_pkg::KIND_OPEN:     map.src = gcsm_pkg::COORD_W'(2);
                gcsm_pkg::KIND_CLOSED:
                begin
                    map.src = gcsm_pkg::COORD_W'(2) + gcsm_pkg::COORD_W'(layer);
                    map.neg = 1'b1;
                end
                gcsm_pkg::KIND_PERIODIC: map.src = n_p1[EW-2:0] - gcsm_pkg::COORD_W'(layer);
                default:                 map.fixed = 1'b1;
            endcase
        end
        else if (is_high)
        begin
            map.ghost     = 1'b1;
            map.high_wall = 1'b1;
            case (hi_kind)
                gcsm_pkg::KIND_OPEN:     map.src = n_p1[EW-2:0];
                gcsm_pkg::KIND_CLOSED:
                begin
                    map.src = n_p1[EW-2:0] - gcsm_pkg::COORD_W'(layer);
                    map.neg = 1'b1;
                end
                gcsm_pkg::KIND_PERIODIC: map.src = gcsm_pkg::COORD_W'(2) + gcsm_pkg::COORD_W'(layer);
                default:                 map.fixed = 1'b1;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcsm_checker.sv @@
// Port-level checker for ghost_cell_source_mapper_core, bound to the top.
// Depends on gcsm_pkg.
`default_nettype none

module gcsm_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [gcsm_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic       negx;
    logic       negy;
    logic       fix;
    logic       ghost;

    assign negx  = m_tdata[20];
    assign negy  = m_tdata[21];
    assign fix   = m_tdata[22];
    assign ghost = m_tdata[25];

    // stalled output beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // a fixed vector zeroes the source coordinate
    a_fixed_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && fix |-> m_tdata[19:0] == 20'd0)
        else $error("fixed vector with nonzero source");

    // an x-momentum flip never accompanies a fixed vector
    a_fixed_no_negx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && fix |-> !negx)
        else $error("x negation with fixed vector");

    // interior and outside cells carry no wall effect
    a_interior_plain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !ghost |-> !negx && !negy && !fix && m_tdata[24:23] == 2'd0)
        else $error("wall effect on non-ghost cell");

endmodule

bind ghost_cell_source_mapper_core gcsm_checker u_gcsm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/ghost_cell_source_mapper_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ghost_cell_source_mapper_core: random wall setups, cell
// coordinates clustered on the ghost layers, random stalls on both streams.
// Depends on gcsm_pkg and the RTL of the mapper core.

module ghost_cell_source_mapper_core_tb;
    import gcsm_pkg::*;

    localparam int STALL_LIMIT   = 5000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 4;     // pipeline is two deep
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_CELLS   = 105;

    // One result beat, laid out as on m_tdata (last field in the low bits)
    typedef struct packed {
        logic [4:0] pad;
        logic       cfg_err;
        logic       is_ghost;
        logic [1:0] fixed_wall;
        logic       take_fixed;
        logic       neg_y;
        logic       neg_x;
        coord_t     src_y;
        coord_t     src_x;
    } cell_source_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_W-1:0]    cfg_data  = '0;

    // Shadow of the register file as written
    coord_t     width_reg   = EXTENT_RST;
    coord_t     height_reg  = EXTENT_RST;
    wall_kind_t left_wall   = KIND_OPEN;
    wall_kind_t right_wall  = KIND_OPEN;
    wall_kind_t bottom_wall = KIND_OPEN;
    wall_kind_t top_wall    = KIND_OPEN;

    cell_source_t expected_sources[$];
    int           mismatches     = 0;
    int           quiet_cycles   = 0;
    bit           src_gaps_on    = 1'b0;
    bit           sink_stalls_on = 1'b0;
    int           sink_hold_req  = 0;

    ghost_cell_source_mapper_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int limit_extent(coord_t n);
        if (n < EXTENT_MIN)
            return int'(EXTENT_MIN);
        if (n > EXTENT_MAX)
            return int'(EXTENT_MAX);
        return int'(n);
    endfunction

    // Ghost handling along one axis; k counts layers outward from the interior
    function automatic axis_map_t map_one_axis(int c, int n, wall_kind_t lo_kind,
                                               wall_kind_t hi_kind);
        axis_map_t m;
        int        k;
        m     = '0;
        m.src = coord_t'(c);
        if (c > n + 3) begin
            m.outside = 1'b1;
        end
        else if (c < 2) begin
            m.ghost = 1'b1;
            k = 1 - c;
            case (lo_kind)
                KIND_OPEN:     m.src = coord_t'(2);
                KIND_CLOSED:
                begin
                    m.src = coord_t'(2 + k);
                    m.neg = 1'b1;
                end
                KIND_PERIODIC: m.src = coord_t'(n + 1 - k);
                default:       m.fixed = 1'b1;
            endcase
        end
        else if (c > n + 1) begin
            m.ghost     = 1'b1;
            m.high_wall = 1'b1;
            k = c - (n + 2);
            case (hi_kind)
                KIND_OPEN:     m.src = coord_t'(n + 1);
                KIND_CLOSED:
                begin
                    m.src = coord_t'(n + 1 - k);
                    m.neg = 1'b1;
                end
                KIND_PERIODIC: m.src = coord_t'(2 + k);
                default:       m.fixed = 1'b1;
            endcase
        end
        return m;
    endfunction

    // Where the cell's value comes from: the y pass is composed onto the x pass
    function automatic cell_source_t predict_source(coord_t x, coord_t y);
        cell_source_t r;
        axis_map_t    mx;
        axis_map_t    my;
        mx = map_one_axis(int'(x), limit_extent(width_reg), left_wall, right_wall);
        my = map_one_axis(int'(y), limit_extent(height_reg), bottom_wall, top_wall);
        r       = '0;
        r.src_x = x;
        r.src_y = y;
        r.cfg_err = ((left_wall == KIND_PERIODIC) != (right_wall == KIND_PERIODIC)) ||
                    ((bottom_wall == KIND_PERIODIC) != (top_wall == KIND_PERIODIC));
        if (!mx.outside && !my.outside) begin
            r.is_ghost = mx.ghost || my.ghost;
            if (my.fixed) begin
                // y wall vector wins, no flips at all
                r.take_fixed = 1'b1;
                r.fixed_wall = my.high_wall ? WALL_TOP : WALL_BOTTOM;
            end
            else begin
                r.src_y = my.src;
                r.neg_y = my.neg;
                if (mx.fixed) begin
                    // x wall vector, y flip still applies
                    r.take_fixed = 1'b1;
                    r.fixed_wall = mx.high_wall ? WALL_RIGHT : WALL_LEFT;
                end
                else begin
                    r.src_x = mx.src;
                    r.neg_x = mx.neg;
                end
            end
            if (r.take_fixed) begin
                r.src_x = '0;
                r.src_y = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Coordinates cluster on both ghost layers and the interior rim
    function automatic coord_t pick_coord(int n);
        int r;
        int pick;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            case ($urandom_range(0, 8))
                0:       pick = 0;
                1:       pick = 1;
                2:       pick = 2;
                3:       pick = 3;
                4:       pick = n;
                5:       pick = n + 1;
                6:       pick = n + 2;
                7:       pick = n + 3;
                default: pick = n + 4;
            endcase
        end
        else if (r < 8)
            pick = $urandom_range(2, n + 1);
        else if (r == 8 || n + 4 > 1023)
            pick = $urandom_range(0, 1023);
        else
            pick = $urandom_range(n + 4, 1023);
        return coord_t'(pick);
    endfunction

    // Small grids mostly; clamped and extreme extents now and then
    function automatic coord_t pick_extent();
        case ($urandom_range(0, 5))
            0:       return coord_t'($urandom_range(0, 3));
            1:       return coord_t'($urandom_range(1017, 1023));
            2:       return coord_t'($urandom_range(0, 1023));
            default: return coord_t'($urandom_range(2, 12));
        endcase
    endfunction

    // One cell beat; expectation is queued at the accepting edge
    task automatic send_cell(coord_t x, coord_t y);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 2 * COORD_W){1'b0}}, y, x};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        expected_sources.push_back(predict_source(x, y));
    endtask

    // Stop offering beats and let every result come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_sources.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic drive_reg(cfg_reg_t idx, coord_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Writes all six registers; caller makes sure the pipe is empty
    task automatic apply_walls(coord_t w, coord_t h, wall_kind_t lk, wall_kind_t rk,
                               wall_kind_t bk, wall_kind_t tk);
        drive_reg(REG_WIDTH, w);
        drive_reg(REG_HEIGHT, h);
        drive_reg(REG_LEFT, coord_t'(lk));
        drive_reg(REG_RIGHT, coord_t'(rk));
        drive_reg(REG_BOTTOM, coord_t'(bk));
        drive_reg(REG_TOP, coord_t'(tk));
        cfg_we      <= 1'b0;
        width_reg   = w;
        height_reg  = h;
        left_wall   = lk;
        right_wall  = rk;
        bottom_wall = bk;
        top_wall    = tk;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset setup: 64x64 interior, all walls open
    task automatic test_reset_state();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_cell(0, 0);
        send_cell(1, 40);
        send_cell(2, 2);
        send_cell(65, 65);
        send_cell(66, 1);
        send_cell(67, 67);
        send_cell(68, 10);
        send_cell(1023, 1023);
        wait_drain();
    endtask

    // Each wall kind on some side, corners, one-sided and two-sided periodic
    task automatic test_wall_kinds();
        apply_walls(5, 4, KIND_CLOSED, KIND_PERIODIC, KIND_OPEN, KIND_FIXED);
        send_cell(0, 3);
        send_cell(1, 3);
        send_cell(7, 3);
        send_cell(8, 3);
        send_cell(4, 0);
        send_cell(4, 7);
        send_cell(0, 7);   // x mirror under a fixed top: top vector wins
        send_cell(8, 0);   // periodic x composed with open bottom
        send_cell(9, 3);   // just past the padded grid
        wait_drain();
        apply_walls(6, 3, KIND_FIXED, KIND_FIXED, KIND_CLOSED, KIND_PERIODIC);
        send_cell(0, 4);
        send_cell(9, 2);
        send_cell(1, 0);   // fixed left with bottom flip kept
        send_cell(8, 6);
        send_cell(3, 5);
        wait_drain();
        apply_walls(3, 3, KIND_PERIODIC, KIND_PERIODIC, KIND_CLOSED, KIND_CLOSED);
        send_cell(0, 1);
        send_cell(6, 5);
        wait_drain();
    endtask

    // Extents below the minimum and above the maximum get clamped
    task automatic test_extent_clamp();
        apply_walls(0, 1023, KIND_OPEN, KIND_CLOSED, KIND_FIXED, KIND_OPEN);
        send_cell(5, 1023);
        send_cell(6, 0);
        send_cell(4, 1021);
        send_cell(1023, 1022);
        wait_drain();
    endtask

    // Output held off long enough to back up the input, then a full drain
    task automatic test_backpressure();
        apply_walls(8, 8, KIND_CLOSED, KIND_OPEN, KIND_PERIODIC, KIND_PERIODIC);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b1;
        sink_hold_req  = 300;
        repeat (60) send_cell(pick_coord(8), pick_coord(8));
        wait_drain();
        src_gaps_on = 1'b1;
        repeat (20) send_cell(pick_coord(8), pick_coord(8));
        wait_drain();
    endtask

    // Random wall setups; left/right walk through all sixteen pairings
    task automatic test_random_walls();
        coord_t w;
        coord_t h;
        int     nx;
        int     ny;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:
                begin
                    w = 0;
                    h = 1;
                end
                1:
                begin
                    w = 1023;
                    h = EXTENT_MAX;
                end
                2:
                begin
                    w = EXTENT_MIN;
                    h = 1022;
                end
                default:
                begin
                    w = pick_extent();
                    h = pick_extent();
                end
            endcase
            apply_walls(w, h, wall_kind_t'(p % 4), wall_kind_t'(p / 4),
                        wall_kind_t'((p + 1) % 4), wall_kind_t'((p / 4 + 2 * p) % 4));
            src_gaps_on    = (p % 3 != 2);
            sink_stalls_on = (p % 4 != 3);
            nx = limit_extent(w);
            ny = limit_extent(h);
            repeat (PHASE_CELLS) send_cell(pick_coord(nx), pick_coord(ny));
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing and end of run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_wall_kinds();
        test_extent_clamp();
        test_backpressure();
        test_random_walls();
        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_sources.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stall runs, or one long hold-off when asked
    initial
    begin : sink_proc
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (sink_hold_req > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_req) @(posedge clk);
                sink_hold_req = 0;
            end
            else if (!sink_stalls_on) begin
                m_tready <= 1'b1;
            end
            else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    m_tready <= 1'b1;
                end
                else begin
                    m_tready <= 1'b0;
                    stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Each result beat against the oldest pending expectation
    always @(posedge clk)
    begin : check_source
        cell_source_t got;
        cell_source_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            got = cell_source_t'(m_tdata);
            if (expected_sources.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                mismatches++;
            end
            else begin
                want = expected_sources.pop_front();
                check_field("source_x", want.src_x, got.src_x);
                check_field("source_y", want.src_y, got.src_y);
                check_field("negate_x_momentum", want.neg_x, got.neg_x);
                check_field("negate_y_momentum", want.neg_y, got.neg_y);
                check_field("take_fixed", want.take_fixed, got.take_fixed);
                check_field("fixed_wall", want.fixed_wall, got.fixed_wall);
                check_field("is_ghost", want.is_ghost, got.is_ghost);
                check_field("config_error", want.cfg_err, got.cfg_err);
                check_field("tdata padding", want.pad, got.pad);
            end
        end
    end

    // Watchdog: too long without a beat on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            quiet_cycles = 0;
        end
        else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
